@@ hdl/srcr_pkg.sv @@
// package for the score and region replacement policy
// holds widths, defaults, state types and saturating score helpers; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package srcr_pkg;
    localparam int SET_COUNT_DEF     = 2048;
    localparam int WAY_COUNT_DEF     = 16;
    localparam int HISTORY_DEPTH_DEF = 32;
    localparam int REGION_SHIFT_DEF  = 9;
    localparam int ADDRESS_BITS_DEF  = 48;

    localparam int SET_W    = 11;
    localparam int WAY_W    = 4;
    localparam int ADDR_W   = 48;
    localparam int SIG_W    = 12;
    localparam int SCORE_W  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 4;

    localparam logic [SCORE_W-1:0] SCORE_TOP = 4'd15;

    localparam logic [CFG_IDX_W-1:0] REG_HIT_GAIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MISS_STEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_BONUS  = 2'd2;

    localparam logic [CFG_W-1:0] HIT_GAIN_RST     = 4'd2;
    localparam logic [CFG_W-1:0] MISS_STEP_RST    = 4'd1;
    localparam logic [CFG_W-1:0] MATCH_BONUS_RST  = 4'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_WRITE,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        HP_IDLE,
        HP_META,
        HP_SCAN
    } hist_phase_t;

    function automatic logic [SCORE_W-1:0] sat_add(input logic [SCORE_W-1:0] s,
                                                   input logic [CFG_W-1:0] d);
        logic [SCORE_W:0] r;
        r = {1'b0, s} + {1'b0, d};
        return r[SCORE_W] ? SCORE_TOP : r[SCORE_W-1:0];
    endfunction

    function automatic logic [SCORE_W-1:0] sat_sub(input logic [SCORE_W-1:0] s,
                                                   input logic [CFG_W-1:0] d);
        return (s >= d) ? s - d : '0;
    endfunction
endpackage
`default_nettype wire

@@ hdl/srcr_if.sv @@
// valid/ready channel interfaces for items and configuration writes
// depends on srcr_pkg
`timescale 1ns / 1ps
`default_nettype none
interface srcr_in_if;
    import srcr_pkg::*;
    logic              valid;
    logic              ready;
    logic              mode;
    logic [SET_W-1:0]  set_index;
    logic [WAY_W-1:0]  way;
    logic [ADDR_W-1:0] address;
    logic [SIG_W-1:0]  pc_signature;
    logic              hit;
    modport source (output valid, mode, set_index, way, address, pc_signature, hit,
                    input ready);
    modport sink (input valid, mode, set_index, way, address, pc_signature, hit,
                  output ready);
endinterface

interface srcr_out_if;
    import srcr_pkg::*;
    logic             valid;
    logic             ready;
    logic [WAY_W-1:0] victim_way;
    modport source (output valid, victim_way, input ready);
    modport sink (input valid, victim_way, output ready);
endinterface

interface srcr_cfg_if;
    import srcr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hdl/srcr_hist.sv @@
// per-set pc signature history: circular buffer in memory plus fill/head memory
// counts matches one entry per cycle; depends on srcr_pkg
`timescale 1ns / 1ps
`default_nettype none
module srcr_hist #(
    parameter int SET_COUNT     = srcr_pkg::SET_COUNT_DEF,
    parameter int HISTORY_DEPTH = srcr_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         clear_en,
    input  wire logic [$clog2(SET_COUNT+1)-1:0] clear_addr,
    input  wire logic                         start,
    input  wire logic [$clog2(SET_COUNT+1)-1:0] set_sel,
    input  wire logic [srcr_pkg::SIG_W-1:0]   sig,
    input  wire logic                         push,
    output logic                              busy,
    output logic [$clog2(HISTORY_DEPTH+1)-1:0] count
);
    import srcr_pkg::*;
    localparam int SA = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int HA = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FW = $clog2(HISTORY_DEPTH + 1);
    localparam int BD = SET_COUNT * HISTORY_DEPTH;
    localparam int BA = (BD > 1) ? $clog2(BD) : 1;

    logic [FW+HA-1:0] meta_mem [SET_COUNT];
    logic [SIG_W-1:0] buf_mem [BD];

    logic [SA-1:0] set_reg;
    logic [FW+HA-1:0] meta_q;
    logic [SIG_W-1:0] buf_q;
    logic [FW-1:0] idx_reg, count_reg;
    hist_phase_t phase_reg, phase_next;
    logic rd_valid_reg;
    logic [FW-1:0] fill;
    logic [HA-1:0] head;
    logic [BA-1:0] rd_addr;
    logic [BA-1:0] wr_addr;
    logic [FW:0] slot;
    logic [FW-1:0] fill_next;
    logic [HA-1:0] head_next;

    assign fill = meta_q[FW+HA-1:HA];
    assign head = meta_q[HA-1:0];
    assign rd_addr = BA'(set_reg * HISTORY_DEPTH) + BA'(idx_reg);

    always_comb
    begin
        slot = {1'b0, fill} + (FW+1)'(head);
        if (slot >= (FW+1)'(HISTORY_DEPTH))
            slot = slot - (FW+1)'(HISTORY_DEPTH);
        fill_next = fill;
        head_next = head;
        if (fill < FW'(HISTORY_DEPTH))
        begin
            fill_next = fill + 1'b1;
            wr_addr = BA'(set_reg * HISTORY_DEPTH) + BA'(slot);
        end
        else
        begin
            wr_addr = BA'(set_reg * HISTORY_DEPTH) + BA'(head);
            head_next = (head == HA'(HISTORY_DEPTH - 1)) ? '0 : head + 1'b1;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            HP_IDLE:
                if (start)
                    phase_next = HP_META;
            HP_META:
                phase_next = HP_SCAN;
            HP_SCAN:
                if (idx_reg >= fill && !rd_valid_reg)
                    phase_next = HP_IDLE;
            default: phase_next = HP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= HP_IDLE;
            rd_valid_reg <= 1'b0;
            idx_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            rd_valid_reg <= 1'b0;
            if (phase_reg == HP_IDLE && start)
            begin
                count_reg <= '0;
                idx_reg <= '0;
            end
            if (phase_reg == HP_SCAN)
            begin
                if (rd_valid_reg && buf_q == sig)
                    count_reg <= count_reg + 1'b1;
                if (idx_reg < fill)
                begin
                    rd_valid_reg <= 1'b1;
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            set_reg <= set_sel[SA-1:0];
        meta_q <= meta_mem[start ? set_sel[SA-1:0] : set_reg];
        buf_q <= buf_mem[rd_addr];
        if (clear_en)
            meta_mem[clear_addr[SA-1:0]] <= '0;
        else if (push)
        begin
            meta_mem[set_reg] <= {fill_next, head_next};
            buf_mem[wr_addr] <= sig;
        end
    end

    assign busy = (phase_reg != HP_IDLE) || start;
    assign count = count_reg;
endmodule
`default_nettype wire

@@ hdl/score_region_cache_replacement.sv @@
// top level of the score and region replacement policy
// depends on srcr_pkg, srcr_if, srcr_hist
//
// usage: items arrive on the in channel. mode 0 asks for a victim way and gives
// one item on the out channel; mode 1 updates the addressed way and gives none.
// configuration writes arrive on the cfg channel, index 0 hit gain, 1 miss step,
// 2 match bonus; they are taken at any time and meant for idle periods.
// one item at a time: a victim request reads its row one way per cycle in the
// scan state and offers its result in the out state; the next item is taken
// only once the result has been taken.
// an update scans both histories of its set one entry per cycle, then writes
// back; the next item waits for the fuller of the two histories to finish.
// after reset a clearing pass runs through every way of every set of the row
// memory and clears the history fill/head memories; in is not ready until done.
// the result sits in an output register; a stalled receiver holds the block
// until the result is taken.
//
`timescale 1ns / 1ps
`default_nettype none
module score_region_cache_replacement #(
    parameter int SET_COUNT     = srcr_pkg::SET_COUNT_DEF,
    parameter int WAY_COUNT     = srcr_pkg::WAY_COUNT_DEF,
    parameter int HISTORY_DEPTH = srcr_pkg::HISTORY_DEPTH_DEF,
    parameter int REGION_SHIFT  = srcr_pkg::REGION_SHIFT_DEF,
    parameter int ADDRESS_BITS  = srcr_pkg::ADDRESS_BITS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    srcr_in_if.sink   in_ch,
    srcr_out_if.source out_ch,
    srcr_cfg_if.sink  cfg
);
    import srcr_pkg::*;
    localparam int SA = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int SC = $clog2(SET_COUNT + 1);
    localparam int WA = $clog2(WAY_COUNT);
    localparam int WC = $clog2(WAY_COUNT + 1);
    localparam int RW = ADDRESS_BITS - REGION_SHIFT;
    localparam int EW = 1 + SCORE_W + RW;
    localparam int HC = $clog2(HISTORY_DEPTH + 1);
    localparam int RA = (SET_COUNT * WAY_COUNT > 1) ? $clog2(SET_COUNT * WAY_COUNT) : 1;

    logic [EW-1:0] row_mem [SET_COUNT * WAY_COUNT];
    logic [EW-1:0] row_q;

    state_t state_reg, state_next;
    logic [SC-1:0] clr_reg;
    logic [WA-1:0] clr_way_reg;
    logic [CFG_W-1:0] hit_gain_reg, miss_step_reg, match_bonus_reg;
    logic mode_reg, hit_reg;
    logic [SA-1:0] set_reg;
    logic [WAY_W-1:0] way_reg;
    logic [RW-1:0] region_reg;
    logic [SIG_W-1:0] sig_reg;
    logic [WC-1:0] scan_reg;
    logic scan_v_reg;
    logic inval_found_reg;
    logic [WAY_W-1:0] inval_way_reg, first_reg, pick_reg;
    logic [SCORE_W:0] best_reg;
    logic pick_found_reg;
    logic [WAY_W-1:0] victim_reg;
    logic hist_started_reg;
    logic [SCORE_W-1:0] new_score;
    // a delayed copy of the way under scan matches the registered read data
    logic [WAY_W-1:0] scan_way_d;

    logic row_valid;
    logic [SCORE_W-1:0] row_score;
    logic [RW-1:0] row_region;
    logic [RA-1:0] rd_addr;
    logic [WAY_W-1:0] scan_way;
    logic in_take, clearing, hit_busy, miss_busy, way_ok;
    logic [HC-1:0] hit_cnt, miss_cnt;
    logic hist_start, hit_push, miss_push;

    assign row_valid = row_q[EW-1];
    assign row_score = row_q[EW-2 -: SCORE_W];
    assign row_region = row_q[RW-1:0];
    assign clearing = (state_reg == ST_CLEAR);
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_take = in_ch.valid && in_ch.ready;
    assign cfg.ready = 1'b1;
    assign out_ch.valid = (state_reg == ST_OUT);
    assign out_ch.victim_way = victim_reg;
    assign scan_way = WAY_W'(scan_reg);
    assign way_ok = (int'(way_reg) < WAY_COUNT);
    assign hist_start = (state_reg == ST_READ) && mode_reg && !hist_started_reg;
    assign hit_push = (state_reg == ST_WRITE) && hit_reg && way_ok;
    assign miss_push = (state_reg == ST_WRITE) && !hit_reg && way_ok;

    always_comb
    begin
        if (state_reg == ST_READ && mode_reg)
            rd_addr = RA'(set_reg * WAY_COUNT) + RA'(way_reg);
        else
            rd_addr = RA'(set_reg * WAY_COUNT) + RA'(scan_reg);
    end

    srcr_hist #(.SET_COUNT(SET_COUNT), .HISTORY_DEPTH(HISTORY_DEPTH)) u_hit_hist (
        .clk(clk), .rst_n(rst_n), .clear_en(clearing), .clear_addr(clr_reg),
        .start(hist_start), .set_sel(SC'(set_reg)), .sig(sig_reg), .push(hit_push),
        .busy(hit_busy), .count(hit_cnt)
    );

    srcr_hist #(.SET_COUNT(SET_COUNT), .HISTORY_DEPTH(HISTORY_DEPTH)) u_miss_hist (
        .clk(clk), .rst_n(rst_n), .clear_en(clearing), .clear_addr(clr_reg),
        .start(hist_start), .set_sel(SC'(set_reg)), .sig(sig_reg), .push(miss_push),
        .busy(miss_busy), .count(miss_cnt)
    );

    always_comb
    begin
        logic [SCORE_W-1:0] s;
        s = row_score;
        if (hit_reg)
            s = sat_add(s, hit_gain_reg);
        else if (hit_cnt >= miss_cnt)
            s = sat_add(s, miss_step_reg);
        else
            s = sat_sub(s, miss_step_reg);
        if (row_region == region_reg)
            s = sat_add(s, match_bonus_reg);
        new_score = s;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
                if (clr_reg == SC'(SET_COUNT - 1) && clr_way_reg == WA'(WAY_COUNT - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_take)
                    state_next = ST_READ;
            ST_READ:
                if (!mode_reg)
                    state_next = ST_SCAN;
                else if (hist_started_reg && !hit_busy && !miss_busy)
                    state_next = ST_WRITE;
            ST_SCAN:
                if (!scan_v_reg && scan_reg == WC'(WAY_COUNT))
                    state_next = ST_OUT;
            ST_WRITE:
                state_next = ST_IDLE;
            ST_OUT:
                if (out_ch.ready)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            clr_way_reg <= '0;
            hit_gain_reg <= HIT_GAIN_RST;
            miss_step_reg <= MISS_STEP_RST;
            match_bonus_reg <= MATCH_BONUS_RST;
            hist_started_reg <= 1'b0;
            scan_reg <= '0;
            scan_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                if (clr_way_reg == WA'(WAY_COUNT - 1))
                begin
                    clr_way_reg <= '0;
                    clr_reg <= clr_reg + 1'b1;
                end
                else
                    clr_way_reg <= clr_way_reg + 1'b1;
            end
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_HIT_GAIN:    hit_gain_reg <= cfg.data;
                    REG_MISS_STEP:   miss_step_reg <= cfg.data;
                    REG_MATCH_BONUS: match_bonus_reg <= cfg.data;
                    default: ;
                endcase
            end
            if (in_take)
                hist_started_reg <= 1'b0;
            else if (state_reg == ST_READ)
                hist_started_reg <= 1'b1;
            scan_v_reg <= 1'b0;
            if (in_take)
                scan_reg <= '0;
            else if (state_reg == ST_SCAN && scan_reg < WC'(WAY_COUNT))
            begin
                scan_reg <= scan_reg + 1'b1;
                scan_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_q <= row_mem[rd_addr];
        scan_way_d <= scan_way;
        if (in_take)
        begin
            mode_reg <= in_ch.mode;
            hit_reg <= in_ch.hit;
            set_reg <= SA'(in_ch.set_index % SET_COUNT);
            way_reg <= in_ch.way;
            region_reg <= in_ch.address[ADDRESS_BITS-1:REGION_SHIFT];
            sig_reg <= in_ch.pc_signature;
            inval_found_reg <= 1'b0;
            pick_found_reg <= 1'b0;
            best_reg <= {1'b1, {SCORE_W{1'b0}}};
            first_reg <= '0;
            pick_reg <= '0;
            inval_way_reg <= '0;
        end
        if (state_reg == ST_SCAN && scan_v_reg)
        begin
            if (!row_valid && !inval_found_reg)
            begin
                inval_found_reg <= 1'b1;
                inval_way_reg <= scan_way_d;
            end
            if ({1'b0, row_score} < best_reg)
            begin
                best_reg <= {1'b0, row_score};
                first_reg <= scan_way_d;
                pick_found_reg <= (row_region != region_reg);
                pick_reg <= scan_way_d;
            end
            else if ({1'b0, row_score} == best_reg && !pick_found_reg &&
                     row_region != region_reg)
            begin
                pick_found_reg <= 1'b1;
                pick_reg <= scan_way_d;
            end
        end
        if (state_reg == ST_SCAN && state_next == ST_OUT)
            victim_reg <= inval_found_reg ? inval_way_reg :
                          (pick_found_reg ? pick_reg : first_reg);
        if (clearing)
            row_mem[RA'(clr_reg[SA-1:0] * WAY_COUNT) + RA'(clr_way_reg)] <= '0;
        else if (state_reg == ST_WRITE && way_ok)
            row_mem[RA'(set_reg * WAY_COUNT) + RA'(way_reg)] <=
                {1'b1, new_score, region_reg};
    end
endmodule
`default_nettype wire

@@ verif/tb.sv @@
// testbench for score_region_cache_replacement: drives victim requests and
// updates, predicts victim ways with a score/region policy model, checks them
// depends on srcr_pkg, srcr_if and the block
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import srcr_pkg::*;

    localparam int SETS = 2048;
    localparam int WAYS = 16;
    localparam int HDEPTH = 32;
    localparam int IDLE_LIMIT = 131072;

    typedef struct packed {
        logic              mode;
        logic [SET_W-1:0]  set_index;
        logic [WAY_W-1:0]  way;
        logic [ADDR_W-1:0] address;
        logic [SIG_W-1:0]  pc_signature;
        logic              hit;
    } access_t;

    class victim_board;
        logic [CFG_W-1:0] gain_hit, step_miss, boost;
        bit                 vld [SETS][WAYS];
        logic [SCORE_W-1:0] score [SETS][WAYS];
        logic [38:0]        reg_of [SETS][WAYS];
        logic [SIG_W-1:0]   hhist [SETS][HDEPTH];
        logic [SIG_W-1:0]   mhist [SETS][HDEPTH];
        int                 hfill [SETS], hhead [SETS], mfill [SETS], mhead [SETS];
        logic [WAY_W-1:0]   pending_ways [$];
        int                 errors;

        function new();
            gain_hit = HIT_GAIN_RST;
            step_miss = MISS_STEP_RST;
            boost = MATCH_BONUS_RST;
            errors = 0;
            foreach (vld[s, w])
            begin
                vld[s][w] = 0;
                score[s][w] = 0;
                reg_of[s][w] = 0;
            end
            foreach (hfill[s])
            begin
                hfill[s] = 0;
                hhead[s] = 0;
                mfill[s] = 0;
                mhead[s] = 0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
            if (idx == REG_HIT_GAIN)
                gain_hit = v;
            else if (idx == REG_MISS_STEP)
                step_miss = v;
            else if (idx == REG_MATCH_BONUS)
                boost = v;
        endfunction

        function logic [SCORE_W-1:0] clip_add(logic [SCORE_W-1:0] s, logic [CFG_W-1:0] d);
            int r;
            r = s + d;
            return (r > 15) ? 4'd15 : r[3:0];
        endfunction

        function int sig_count(bit from_hits, int s, logic [SIG_W-1:0] sig);
            int n, fill;
            n = 0;
            fill = from_hits ? hfill[s] : mfill[s];
            for (int i = 0; i < fill; i++)
                if ((from_hits ? hhist[s][i] : mhist[s][i]) == sig)
                    n++;
            return n;
        endfunction

        function void note_access(access_t a);
            int s, best, first, pick, nh, nm;
            logic [38:0] rg;
            logic [SCORE_W-1:0] sc;
            s = int'(a.set_index);
            rg = a.address[ADDR_W-1:9];
            if (a.mode == 1'b0)
            begin
                for (int w = 0; w < WAYS; w++)
                    if (!vld[s][w])
                    begin
                        pending_ways = {pending_ways, WAY_W'(w)};
                        return;
                    end
                best = 16;
                first = 0;
                pick = -1;
                for (int w = 0; w < WAYS; w++)
                    if (score[s][w] < best)
                    begin
                        best = score[s][w];
                        first = w;
                    end
                for (int w = WAYS - 1; w >= 0; w--)
                    if (score[s][w] == best && reg_of[s][w] != rg)
                        pick = w;
                pending_ways = {pending_ways, WAY_W'(pick >= 0 ? pick : first)};
                return;
            end
            sc = score[s][a.way];
            if (a.hit)
            begin
                sc = clip_add(sc, gain_hit);
                if (hfill[s] < HDEPTH)
                begin
                    hhist[s][(hhead[s] + hfill[s]) % HDEPTH] = a.pc_signature;
                    hfill[s]++;
                end
                else
                begin
                    hhist[s][hhead[s]] = a.pc_signature;
                    hhead[s] = (hhead[s] + 1) % HDEPTH;
                end
            end
            else
            begin
                nh = sig_count(1, s, a.pc_signature);
                nm = sig_count(0, s, a.pc_signature);
                if (nh >= nm)
                    sc = clip_add(sc, step_miss);
                else
                    sc = (sc >= step_miss) ? sc - step_miss : 4'd0;
            end
            if (reg_of[s][a.way] == rg)
                sc = clip_add(sc, boost);
            score[s][a.way] = sc;
            reg_of[s][a.way] = rg;
            vld[s][a.way] = 1;
            if (!a.hit)
            begin
                if (mfill[s] < HDEPTH)
                begin
                    mhist[s][(mhead[s] + mfill[s]) % HDEPTH] = a.pc_signature;
                    mfill[s]++;
                end
                else
                begin
                    mhist[s][mhead[s]] = a.pc_signature;
                    mhead[s] = (mhead[s] + 1) % HDEPTH;
                end
            end
        endfunction

        function void check_victim(logic [WAY_W-1:0] got);
            logic [WAY_W-1:0] want;
            if (pending_ways.size() == 0)
            begin
                $error("unexpected victim_way item %0d", got);
                errors++;
                return;
            end
            want = pending_ways.pop_front();
            if (want !== got)
            begin
                $error("victim_way expected %0d actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    srcr_in_if  in_ch();
    srcr_out_if out_ch();
    srcr_cfg_if cfg();

    score_region_cache_replacement DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg    (cfg.sink)
    );

    victim_board board;
    int idle_cycles;
    bit long_hold;
    bit hold_done;
    int hot_sets [4];
    logic [38:0] hot_regions [4];

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // acceptance, config write tracking, result check and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                board.note_access({in_ch.mode, in_ch.set_index, in_ch.way, in_ch.address,
                                   in_ch.pc_signature, in_ch.hit});
            if (out_ch.valid && out_ch.ready)
                board.check_victim(out_ch.victim_way);
            if (cfg.valid && cfg.ready)
                board.set_reg(cfg.index, cfg.data);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg.valid && cfg.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb failed");
                $finish;
            end
        end
    end

    // receiver stall pattern, with one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (long_hold && !hold_done)
            out_ch.ready <= 1'b0;
        else
            case ($urandom_range(3))
                0: out_ch.ready <= 1'b0;
                default: out_ch.ready <= 1'b1;
            endcase
    end

    initial
    begin
        hold_done = 0;
        wait (long_hold);
        repeat (300) @(negedge clk);
        hold_done = 1;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= v;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic send_access(access_t a, bit keep);
        in_ch.valid <= 1'b1;
        in_ch.mode <= a.mode;
        in_ch.set_index <= a.set_index;
        in_ch.way <= a.way;
        in_ch.address <= a.address;
        in_ch.pc_signature <= a.pc_signature;
        in_ch.hit <= a.hit;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
        if (!keep)
            in_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (board.pending_ways.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    function automatic access_t random_access();
        access_t a;
        int k;
        k = $urandom_range(3);
        a.set_index = SET_W'(hot_sets[k]);
        a.address = {hot_regions[$urandom_range(3)], 9'(($urandom))};
        if ($urandom_range(9) == 0)
        begin
            a.set_index = SET_W'($urandom);
            a.address = ADDR_W'({$urandom, $urandom});
        end
        a.mode = ($urandom_range(2) != 0);
        a.way = WAY_W'($urandom);
        a.pc_signature = {8'h00, 4'($urandom)};
        if ($urandom_range(7) == 0)
            a.pc_signature = SIG_W'($urandom);
        a.hit = 1'($urandom);
        return a;
    endfunction

    task automatic random_phase(int count);
        access_t a;
        int left;
        left = count;
        while (left > 0)
        begin
            int burst;
            burst = $urandom_range(12, 1);
            for (int i = 0; i < burst && left > 0; i++)
            begin
                a = random_access();
                left--;
                send_access(a, (i < burst - 1) && left > 0);
            end
            if ($urandom_range(2) != 0)
            begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(15)) @(negedge clk);
            end
        end
        in_ch.valid <= 1'b0;
    endtask

    initial
    begin
        access_t a;
        board = new();
        idle_cycles = 0;
        long_hold = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.mode = 1'b0;
        in_ch.set_index = '0;
        in_ch.way = '0;
        in_ch.address = '0;
        in_ch.pc_signature = '0;
        in_ch.hit = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = REG_HIT_GAIN;
        cfg.data = '0;
        for (int i = 0; i < 4; i++)
        begin
            hot_sets[i] = $urandom_range(SETS - 1);
            hot_regions[i] = 39'({$urandom, $urandom});
        end
        hot_sets[0] = SETS - 1;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // directed: fill one set, extremes, saturation, floor and region match
        for (int w = 0; w < WAYS; w++)
        begin
            a = '{1'b1, 11'h7ff, 4'(w), (w[0] ? 48'hffff_ffff_ffff : 48'h0), 12'hfff, w[1]};
            send_access(a, 0);
        end
        send_access('{1'b0, 11'h7ff, 4'd0, 48'h0, 12'h000, 1'b0}, 0);
        send_access('{1'b0, 11'h7ff, 4'd15, 48'hffff_ffff_ffff, 12'hfff, 1'b1}, 0);
        send_access('{1'b0, 11'h000, 4'd0, 48'h0, 12'h0, 1'b0}, 0);
        for (int i = 0; i < 3; i++)
            send_access('{1'b1, 11'h7ff, 4'd3, 48'hffff_ffff_ffff, 12'h123, 1'b0}, 0);
        send_access('{1'b1, 11'h7ff, 4'd5, 48'h1ff, 12'h123, 1'b1}, 0);
        send_access('{1'b0, 11'h7ff, 4'd0, 48'h1ff, 12'h0, 1'b0}, 0);
        drain();

        write_reg(REG_HIT_GAIN, 4'd15);
        write_reg(REG_MISS_STEP, 4'd15);
        write_reg(REG_MATCH_BONUS, 4'd0);
        random_phase(130);
        drain();

        write_reg(REG_HIT_GAIN, 4'd0);
        write_reg(REG_MISS_STEP, 4'd0);
        write_reg(REG_MATCH_BONUS, 4'd15);
        long_hold = 1;
        random_phase(130);
        drain();

        write_reg(REG_HIT_GAIN, 4'($urandom));
        write_reg(REG_MISS_STEP, 4'($urandom));
        write_reg(REG_MATCH_BONUS, 4'($urandom));
        random_phase(130);
        drain();

        if (board.errors == 0 && board.pending_ways.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
`default_nettype wire

@@ score_region_cache_replacement.f @@
hdl/srcr_pkg.sv
hdl/srcr_if.sv
hdl/srcr_hist.sv
hdl/score_region_cache_replacement.sv
verif/tb.sv
